>>> src/arot_pkg.sv
// Shared types and constants for the address range offset table.
// No dependencies.
package arot_pkg;

    localparam int ADDR_W = 64;
    localparam int PERM_W = 8;
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rbegin;
        logic [ADDR_W-1:0] rend;
        logic [ADDR_W-1:0] offset;
        logic [PERM_W-1:0] perms;
    } entry_t;

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [SLOT_OUT_W-1:0] entry_slot;
        logic [ADDR_W-1:0] translated_offset;
        logic [PERM_W-1:0] hit_perms;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> src/arot_mem.sv
// Range entry memory: one write port, one registered read port.
// Depends on arot_pkg.
module arot_mem
    import arot_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/arot_ctrl.sv
// Sequencer: count pass, clip pass, insert and answer over the entry memory.
// Depends on arot_pkg and arot_mem.
module arot_ctrl
    import arot_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  op_t        op,
    input  logic [ADDR_W-1:0] rb,
    input  logic [ADDR_W-1:0] re,
    input  logic [ADDR_W-1:0] roff,
    input  logic [PERM_W-1:0] rperm,
    input  logic [ADDR_W-1:0] laddr,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COUNT = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_CLIP  = 7'b0001000,
        S_SPLIT = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    localparam int CNT_W = IDX_W + 2;

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [ADDR_W-1:0]   b_reg, e_reg, off_reg, a_reg;
    logic [PERM_W-1:0]   perm_reg;
    logic [DEPTH-1:0]    valid_reg, valid_next;
    logic [IDX_W:0]      idx_reg, idx_next;
    logic                rd_ok_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                split_reg, split_next;
    entry_t              split_e_reg, split_e_next;
    result_t             res_reg, res_next;
    logic                found_reg, found_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data, rd_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    free_idx;
    logic                vbit, ov, cut_front, cut_back;
    logic [ADDR_W-1:0]   b_sw, e_sw;

    arot_mem #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr = idx_reg[IDX_W-1:0];
    assign busy    = (state_reg != S_IDLE);
    assign done    = (state_reg == S_DONE);
    assign result  = res_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign vbit      = valid_reg[rd_idx_reg];
    assign ov        = vbit && (rd_data.rbegin < e_reg) && (rd_data.rend > b_reg);
    assign cut_front = rd_data.rbegin < b_reg;
    assign cut_back  = e_reg < rd_data.rend;
    assign b_sw      = (rb > re) ? re : rb;
    assign e_sw      = (rb > re) ? rb : re;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        split_next   = split_reg;
        split_e_next = split_e_reg;
        res_next     = res_reg;
        found_next   = found_reg;
        wr_en        = 1'b0;
        wr_addr      = rd_idx_reg;
        wr_data      = rd_data;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next   = '0;
                    cnt_next   = '0;
                    split_next = 1'b0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (op == OP_LOOKUP || op == OP_ADD
                        || (op == OP_REMOVE && rb < re))
                    begin
                        if (op == OP_ADD && rb == re)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_COUNT;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_COUNT:
            begin
                if (idx_reg != (IDX_W+1)'(DEPTH))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        if (!found_reg && vbit && rd_data.rbegin <= a_reg
                            && a_reg < rd_data.rend)
                        begin
                            found_next           = 1'b1;
                            res_next.hit         = 1'b1;
                            res_next.entry_slot  = SLOT_OUT_W'(rd_idx_reg);
                            res_next.translated_offset =
                                rd_data.offset + (a_reg - rd_data.rbegin);
                            res_next.hit_perms   = rd_data.perms;
                        end
                    end
                    else if (vbit)
                    begin
                        if (!ov)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else if (cut_front)
                        begin
                            cnt_next = cnt_reg + (cut_back ? CNT_W'(2) : CNT_W'(1));
                        end
                        else if (cut_back)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    if (rd_idx_reg == IDX_W'(DEPTH - 1))
                    begin
                        idx_next   = '0;
                        state_next = (op_reg == OP_LOOKUP) ? S_DONE : S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if ({1'b0, cnt_reg} + ((op_reg == OP_ADD) ? (CNT_W+1)'(1) : (CNT_W+1)'(0))
                    > (CNT_W+1)'(DEPTH))
                begin
                    res_next.status = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_CLIP;
                end
            end
            S_CLIP:
            begin
                if (idx_reg != (IDX_W+1)'(DEPTH))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg)
                begin
                    if (ov)
                    begin
                        wr_en = 1'b1;
                        if (cut_front)
                        begin
                            if (cut_back)
                            begin
                                split_next          = 1'b1;
                                split_e_next.rbegin = e_reg;
                                split_e_next.rend   = rd_data.rend;
                                split_e_next.offset =
                                    rd_data.offset + (e_reg - rd_data.rbegin);
                                split_e_next.perms  = rd_data.perms;
                            end
                            wr_data.rend = b_reg;
                        end
                        else if (cut_back)
                        begin
                            wr_data.offset = rd_data.offset + (e_reg - rd_data.rbegin);
                            wr_data.rbegin = e_reg;
                        end
                        else
                        begin
                            wr_en                  = 1'b0;
                            valid_next[rd_idx_reg] = 1'b0;
                        end
                    end
                    if (rd_idx_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT:
            begin
                if (split_reg)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = free_idx;
                    wr_data              = split_e_reg;
                    valid_next[free_idx] = 1'b1;
                end
                state_next = (op_reg == OP_ADD) ? S_ADD : S_DONE;
            end
            S_ADD:
            begin
                wr_en                = 1'b1;
                wr_addr              = free_idx;
                wr_data.rbegin       = b_reg;
                wr_data.rend         = e_reg;
                wr_data.offset       = off_reg;
                wr_data.perms        = perm_reg;
                valid_next[free_idx] = 1'b1;
                state_next           = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            idx_reg   <= '0;
            rd_ok_reg <= 1'b0;
            cnt_reg   <= '0;
            split_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            rd_ok_reg <= (state_reg == S_COUNT || state_reg == S_CLIP)
                         && (idx_reg != (IDX_W+1)'(DEPTH))
                         && (state_next == state_reg);
            cnt_reg   <= cnt_next;
            split_reg <= split_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= idx_reg[IDX_W-1:0];
        split_e_reg <= split_e_next;
        res_reg     <= res_next;
        if (start && state_reg == S_IDLE)
        begin
            op_reg   <= op;
            b_reg    <= (op == OP_ADD) ? b_sw : rb;
            e_reg    <= (op == OP_ADD) ? e_sw : re;
            off_reg  <= roff;
            perm_reg <= rperm;
            a_reg    <= laddr;
        end
    end

endmodule

>>> src/address_range_offset_table.sv
// Address range offset table, top level with stream ports and result register.
// Depends on arot_pkg and arot_ctrl.
//
// Keeps up to MAX_RANGES non-overlapping ranges in one entry memory. Every
// lookup, non-empty add and remove with begin below end sweeps the memory
// once, one read a cycle; add and remove then sweep again to clip unless
// rejected, then store a split piece if there is one, and add then stores
// the new range. An empty add, a remove with begin not below end or an
// unused code goes straight to the result.
// One beat at a time; a waiting result holds off the next input beat.
module address_range_offset_table
    import arot_pkg::*;
#(
    parameter int MAX_RANGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // operation
    input  logic [263:0] s_tdata,   // range_begin, range_end, range_base_offset,
                                    // range_perms, lookup_address
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata    // status, hit, entry_slot, translated_offset,
                                    // hit_perms, zero fill
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic    busy, done, accept;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;

    assign s_tready = !busy && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    arot_ctrl #(.DEPTH(MAX_RANGES), .IDX_W(IDX_W)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .op     (op_t'(s_tuser)),
        .rb     (s_tdata[63:0]),
        .re     (s_tdata[127:64]),
        .roff   (s_tdata[191:128]),
        .rperm  (s_tdata[199:192]),
        .laddr  (s_tdata[263:200]),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.hit_perms, out_reg.translated_offset,
                       out_reg.entry_slot, out_reg.hit, out_reg.status};

endmodule

>>> tb/tb.sv
// Self-checking testbench for address_range_offset_table: add, remove and lookup
// beats are predicted by a behavioral range table and compared field by field.
// Depends on arot_pkg and the address_range_offset_table RTL.
module tb;
    import arot_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 16;
    localparam longint CYCLE_LIMIT = 1500000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [263:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;

    address_range_offset_table #(.MAX_RANGES(NSLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [63:0] tbl_begin [NSLOTS];
    logic [63:0] tbl_end [NSLOTS];
    logic [63:0] tbl_offset [NSLOTS];
    logic [7:0]  tbl_perms [NSLOTS];
    bit          tbl_valid [NSLOTS];

    result_t pending_results[$];
    int      errors = 0;
    longint  cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit hits_span(int i, logic [63:0] b, logic [63:0] e);
        return tbl_valid[i] && tbl_begin[i] < e && tbl_end[i] > b;
    endfunction

    function automatic int count_after_cut(logic [63:0] b, logic [63:0] e);
        int n;
        n = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (!tbl_valid[i])
                continue;
            n++;
            if (!hits_span(i, b, e))
                continue;
            if (tbl_begin[i] < b)
            begin
                if (e < tbl_end[i])
                    n++;
            end
            else if (!(e < tbl_end[i]))
                n--;
        end
        return n;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < NSLOTS; i++)
            if (!tbl_valid[i])
                return i;
        return 0;
    endfunction

    function automatic void put_slot(int i, logic [63:0] b, logic [63:0] e,
                                     logic [63:0] off, logic [7:0] p);
        tbl_begin[i] = b;
        tbl_end[i] = e;
        tbl_offset[i] = off;
        tbl_perms[i] = p;
        tbl_valid[i] = 1'b1;
    endfunction

    function automatic void cut_span(logic [63:0] b, logic [63:0] e);
        bit          split;
        logic [63:0] sb, se, so;
        logic [7:0]  sp;
        split = 0;
        sb = '0; se = '0; so = '0; sp = '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (!hits_span(i, b, e))
                continue;
            if (tbl_begin[i] < b)
            begin
                if (e < tbl_end[i])
                begin
                    split = 1;
                    sb = e;
                    se = tbl_end[i];
                    so = tbl_offset[i] + (e - tbl_begin[i]);
                    sp = tbl_perms[i];
                end
                tbl_end[i] = b;
            end
            else if (e < tbl_end[i])
            begin
                tbl_offset[i] = tbl_offset[i] + (e - tbl_begin[i]);
                tbl_begin[i] = e;
            end
            else
                tbl_valid[i] = 1'b0;
        end
        if (split)
            put_slot(first_free_slot(), sb, se, so, sp);
    endfunction

    function automatic result_t apply_to_table(op_t op, logic [63:0] b, logic [63:0] e,
                                               logic [63:0] off, logic [7:0] p,
                                               logic [63:0] a);
        result_t r;
        logic [63:0] t;
        r = '0;
        case (op)
            OP_LOOKUP:
                for (int i = 0; i < NSLOTS; i++)
                    if (tbl_valid[i] && tbl_begin[i] <= a && a < tbl_end[i])
                    begin
                        r.hit = 1'b1;
                        r.entry_slot = i[3:0];
                        r.translated_offset = tbl_offset[i] + (a - tbl_begin[i]);
                        r.hit_perms = tbl_perms[i];
                        break;
                    end
            OP_ADD:
            begin
                if (b > e)
                begin
                    t = b; b = e; e = t;
                end
                if (b != e)
                begin
                    if (count_after_cut(b, e) + 1 > NSLOTS)
                        r.status = 1'b1;
                    else
                    begin
                        cut_span(b, e);
                        put_slot(first_free_slot(), b, e, off, p);
                    end
                end
            end
            OP_REMOVE:
                if (b < e)
                begin
                    if (count_after_cut(b, e) > NSLOTS)
                        r.status = 1'b1;
                    else
                        cut_span(b, e);
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_beat(op_t op, logic [63:0] b, logic [63:0] e,
                             logic [63:0] off, logic [7:0] p, logic [63:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {a, p, off, e, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_to_table(op, b, e, off, p, a));
    endtask

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[0];
                got.hit = m_tdata[1];
                got.entry_slot = m_tdata[5:2];
                got.translated_offset = m_tdata[69:6];
                got.hit_perms = m_tdata[77:70];
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status exp %0h got %0h", want.status, got.status);
                        errors++;
                    end
                    if (got.hit !== want.hit)
                    begin
                        $error("hit exp %0h got %0h", want.hit, got.hit);
                        errors++;
                    end
                    if (got.entry_slot !== want.entry_slot)
                    begin
                        $error("entry_slot exp %0h got %0h", want.entry_slot,
                               got.entry_slot);
                        errors++;
                    end
                    if (got.translated_offset !== want.translated_offset)
                    begin
                        $error("translated_offset exp %h got %h",
                               want.translated_offset, got.translated_offset);
                        errors++;
                    end
                    if (got.hit_perms !== want.hit_perms)
                    begin
                        $error("hit_perms exp %0h got %0h", want.hit_perms, got.hit_perms);
                        errors++;
                    end
                    if (m_tdata[79:RESULT_W] !== '0)
                    begin
                        $error("zero fill exp 0 got %h", m_tdata[79:RESULT_W]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Addresses drawn from a small window so ranges overlap often.
    function automatic logic [63:0] near_addr(logic [63:0] base);
        return base + 64'($urandom_range(300));
    endfunction

    task automatic test_directed();
        logic [63:0] top;
        top = '1;
        send_beat(OP_LOOKUP, '0, '0, '0, '0, '0);
        send_beat(OP_ADD, 64'd100, 64'd200, 64'd1000, 8'hA5, '0);
        send_beat(OP_ADD, 64'd400, 64'd300, 64'd5000, 8'h5A, '0);
        send_beat(OP_ADD, 64'd50, 64'd50, 64'd1, 8'h01, '0);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd150);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd350);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd200);
        send_beat(OP_REMOVE, 64'd140, 64'd160, '0, '0, '0);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd170);
        send_beat(OP_REMOVE, 64'd90, 64'd110, '0, '0, '0);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd110);
        send_beat(OP_REMOVE, 64'd320, 64'd310, '0, '0, '0);
        send_beat(OP_REMOVE, 64'd290, 64'd410, '0, '0, '0);
        send_beat(OP_NONE, rand64(), rand64(), rand64(), 8'hFF, rand64());
        send_beat(OP_ADD, top - 64'd10, top, top, 8'hFF, top);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, top - 64'd1);
        send_beat(OP_ADD, 64'd0, 64'd5, top, 8'h00, '0);
        send_beat(OP_LOOKUP, '0, '0, '0, '0, 64'd0);
        for (int i = 0; i < 14; i++)
            send_beat(OP_ADD, 64'(1000 + 10 * i), 64'(1005 + 10 * i), 64'(i), 8'(i), '0);
        send_beat(OP_REMOVE, 64'd1001, 64'd1002, '0, '0, '0);
        send_beat(OP_ADD, 64'd2000, 64'd2001, '0, '0, '0);
        send_beat(OP_ADD, '0, top, '0, 8'h3C, '0);
        send_beat(OP_REMOVE, '0, top, '0, '0, '0);
    endtask

    task automatic test_random(int n);
        logic [63:0] base, b, e;
        int          sel;
        base = rand64();
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(60) == 0)
                base = ($urandom_range(3) == 0) ? rand64() : 64'($urandom_range(1000));
            b = near_addr(base);
            e = near_addr(base);
            sel = $urandom_range(99);
            if (sel < 40)
                send_beat(OP_ADD, b, e, rand64(), 8'($urandom), rand64());
            else if (sel < 55)
                send_beat(OP_REMOVE, b, e, rand64(), 8'($urandom), rand64());
            else if (sel < 95)
                send_beat(OP_LOOKUP, rand64(), rand64(), rand64(), 8'($urandom),
                          near_addr(base));
            else if (sel < 98)
                send_beat(OP_LOOKUP, b, e, '0, '0, rand64());
            else
                send_beat(OP_ADD, rand64(), rand64(), rand64(), 8'($urandom), '0);
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tuser = OP_NONE;
        s_tdata = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        for (int i = 0; i < NSLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 62;
        test_directed();
        test_random(450);
        send_idle_pct = 62;
        recv_idle_pct = 15;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(475);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
src/arot_pkg.sv
src/arot_mem.sv
src/arot_ctrl.sv
src/address_range_offset_table.sv
tb/tb.sv
